### rtl/core/ebcpu_pkg.sv
// Package for the eight-bit processor subset unit.
// Holds widths, opcodes, the sequencer state type and the result record.
// No dependencies.
`timescale 1ns / 1ps

package ebcpu_pkg;

	localparam int ADDR_BITS_DEF = 16;
	localparam int WORD_W        = 16;
	localparam int BYTE_W        = 8;
	localparam int STOP_W        = 2;

	localparam logic [WORD_W-1:0] RESET_START  = 16'h0600;
	localparam logic [WORD_W-1:0] CONSOLE_ADDR = 16'h0400;

	// Item commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// Stop reasons
	localparam logic [STOP_W-1:0] STOP_RUN   = 2'd0;
	localparam logic [STOP_W-1:0] STOP_BRK   = 2'd1;
	localparam logic [STOP_W-1:0] STOP_FAULT = 2'd2;

	// Opcodes
	localparam logic [BYTE_W-1:0] OP_BRK     = 8'h00;
	localparam logic [BYTE_W-1:0] OP_JMP_ABS = 8'h4C;
	localparam logic [BYTE_W-1:0] OP_STA_ABS = 8'h8D;
	localparam logic [BYTE_W-1:0] OP_LDY_IMM = 8'hA0;
	localparam logic [BYTE_W-1:0] OP_LDA_ABY = 8'hB9;
	localparam logic [BYTE_W-1:0] OP_INY     = 8'hC8;
	localparam logic [BYTE_W-1:0] OP_BEQ     = 8'hF0;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OP,
		ST_LO,
		ST_HI,
		ST_DATA,
		ST_IMM,
		ST_REL,
		ST_DONE
	} state_t;

	// Result record held in the output register
	typedef struct packed {
		logic [WORD_W-1:0] program_counter;
		logic [BYTE_W-1:0] accumulator;
		logic [BYTE_W-1:0] index_y;
		logic              negative_flag;
		logic              zero_flag;
		logic [STOP_W-1:0] stop_reason;
		logic [BYTE_W-1:0] fault_opcode;
		logic              char_valid;
		logic [BYTE_W-1:0] char_out;
	} result_t;

endpackage

### rtl/core/ebcpu_in_if.sv
// Input channel of the processor subset unit: valid/ready plus item fields.
// Depends on ebcpu_pkg.
`timescale 1ns / 1ps

interface ebcpu_in_if;
	import ebcpu_pkg::*;

	logic              valid;
	logic              ready;
	logic              command;
	logic [WORD_W-1:0] load_address;
	logic [BYTE_W-1:0] load_data;

	modport source (output valid, output command, output load_address, output load_data,
		input ready);
	modport sink (input valid, input command, input load_address, input load_data,
		output ready);
endinterface

### rtl/core/ebcpu_out_if.sv
// Result channel of the processor subset unit: valid/ready plus result fields.
// Depends on ebcpu_pkg.
`timescale 1ns / 1ps

interface ebcpu_out_if;
	import ebcpu_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] program_counter;
	logic [BYTE_W-1:0] accumulator;
	logic [BYTE_W-1:0] index_y;
	logic              negative_flag;
	logic              zero_flag;
	logic [STOP_W-1:0] stop_reason;
	logic [BYTE_W-1:0] fault_opcode;
	logic              char_valid;
	logic [BYTE_W-1:0] char_out;

	modport source (output valid, output program_counter, output accumulator,
		output index_y, output negative_flag, output zero_flag, output stop_reason,
		output fault_opcode, output char_valid, output char_out, input ready);
	modport sink (input valid, input program_counter, input accumulator,
		input index_y, input negative_flag, input zero_flag, input stop_reason,
		input fault_opcode, input char_valid, input char_out, output ready);
endinterface

### rtl/core/eight_bit_cpu_instruction_subset_unit.sv
// Top level of the eight-bit processor subset unit: byte memory, sequencer,
// architectural registers and result register.
// Depends on ebcpu_pkg, ebcpu_in_if and ebcpu_out_if.
`timescale 1ns / 1ps

// Usage
//  cmd : one transaction per item. command 0 writes load_data to memory at
//        load_address; command 1 fetches and executes one instruction.
//  res : one transaction per item with the register state after it and any
//        console character stored to address 0x0400.
//  cfg : cfg_we with cfg_wdata sets the start address and the program counter;
//        write only while the unit is idle.
// Sequencing
//  Program and data sit in a single-port byte memory with a registered read.
//  Each memory access takes its own sequencer state: the opcode, then the
//  operand bytes and data as the instruction needs. A new item is accepted
//  only once the previous one has finished and its result can be registered.
// Reset
//  After arst_n the memory is cleared, one byte per cycle, across all
//  2^ADDR_BITS addresses; cmd.ready stays low during that pass.
// Back-pressure
//  The result register lets the next item be accepted while a result waits;
//  an item that finishes while the register is still full holds until
//  res.ready, and cmd.ready drops meanwhile.
module eight_bit_cpu_instruction_subset_unit #(
	parameter int ADDR_BITS = ebcpu_pkg::ADDR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ebcpu_pkg::WORD_W-1:0]  cfg_wdata,
	ebcpu_in_if.sink                      cmd,
	ebcpu_out_if.source                   res
);
	import ebcpu_pkg::*;

	localparam int MEM_DEPTH = 1 << ADDR_BITS;

	// Memory
	logic [BYTE_W-1:0]    mem_q [0:MEM_DEPTH-1];
	logic [BYTE_W-1:0]    rdata_q;
	logic                 mem_we;
	logic [ADDR_BITS-1:0] mem_addr;
	logic [BYTE_W-1:0]    mem_wdata;

	// Clearing pass
	logic [ADDR_BITS:0]   clr_cnt_q;
	logic                 clearing;

	// Sequencer
	state_t state_q, state_d;
	logic   push;
	logic   acc_ok;
	logic   accept;
	logic   step_run;

	// Architectural state
	logic [WORD_W-1:0] pc_q;
	logic [BYTE_W-1:0] acc_q;
	logic [BYTE_W-1:0] y_q;
	logic              n_q;
	logic              z_q;
	logic [STOP_W-1:0] stop_q;
	logic [BYTE_W-1:0] fault_q;
	logic              char_v_q;
	logic [BYTE_W-1:0] char_q;
	logic [BYTE_W-1:0] op_q;
	logic [BYTE_W-1:0] lo_q;

	// Output register
	logic    out_valid_q;
	result_t res_q;

	logic [WORD_W-1:0] abs_addr;
	logic [WORD_W-1:0] idx_addr;
	logic [BYTE_W-1:0] y_inc;

	assign clearing = ~clr_cnt_q[ADDR_BITS];
	assign push     = (state_q == ST_DONE) && (!out_valid_q || res.ready);
	assign acc_ok   = !clearing && ((state_q == ST_IDLE) || push);
	assign accept   = acc_ok && cmd.valid;
	assign step_run = (cmd.command == CMD_STEP) && (stop_q == STOP_RUN);
	assign cmd.ready = acc_ok;

	assign abs_addr = {rdata_q, lo_q};
	assign idx_addr = abs_addr + {{(WORD_W-BYTE_W){1'b0}}, y_q};
	assign y_inc    = y_q + 8'd1;

	// Clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clearing) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = pc_q[ADDR_BITS-1:0];
		mem_wdata = acc_q;
		if (clearing) begin
			mem_we    = 1'b1;
			mem_addr  = clr_cnt_q[ADDR_BITS-1:0];
			mem_wdata = '0;
		end else if (accept && cmd.command == CMD_LOAD) begin
			mem_we    = 1'b1;
			mem_addr  = cmd.load_address[ADDR_BITS-1:0];
			mem_wdata = cmd.load_data;
		end else if (state_q == ST_HI) begin
			if (op_q == OP_STA_ABS) begin
				mem_we   = 1'b1;
				mem_addr = abs_addr[ADDR_BITS-1:0];
			end else begin
				mem_addr = idx_addr[ADDR_BITS-1:0];
			end
		end
	end

	// Single-port byte memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		rdata_q <= mem_q[mem_addr];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE, ST_DONE: begin
				if (state_q == ST_DONE && push) begin
					state_d = ST_IDLE;
				end
				if (accept) begin
					state_d = step_run ? ST_OP : ST_DONE;
				end
			end
			ST_OP: begin
				priority case (rdata_q)
					OP_JMP_ABS, OP_STA_ABS, OP_LDA_ABY: state_d = ST_LO;
					OP_LDY_IMM:                         state_d = ST_IMM;
					OP_BEQ:                             state_d = ST_REL;
					default:                            state_d = ST_DONE;
				endcase
			end
			ST_LO:   state_d = ST_HI;
			ST_HI:   state_d = (op_q == OP_LDA_ABY) ? ST_DATA : ST_DONE;
			ST_DATA: state_d = ST_DONE;
			ST_IMM:  state_d = ST_DONE;
			ST_REL:  state_d = ST_DONE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Operand latches
	always_ff @(posedge clk) begin
		if (state_q == ST_OP) begin
			op_q <= rdata_q;
		end
		if (state_q == ST_LO) begin
			lo_q <= rdata_q;
		end
	end

	// Architectural registers: execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= RESET_START;
			acc_q    <= '0;
			y_q      <= '0;
			n_q      <= 1'b0;
			z_q      <= 1'b0;
			stop_q   <= STOP_RUN;
			fault_q  <= '0;
			char_v_q <= 1'b0;
			char_q   <= '0;
		end else begin
			if (accept) begin
				char_v_q <= 1'b0;
				char_q   <= '0;
				if (step_run) begin
					pc_q <= pc_q + 16'd1;
				end
			end
			unique case (state_q)
				ST_OP: begin
					priority case (rdata_q)
						OP_BRK: stop_q <= STOP_BRK;
						OP_JMP_ABS, OP_STA_ABS, OP_LDA_ABY, OP_LDY_IMM, OP_BEQ:
							pc_q <= pc_q + 16'd1;
						OP_INY: begin
							y_q <= y_inc;
							n_q <= y_inc[BYTE_W-1];
							z_q <= (y_inc == '0);
						end
						default: begin
							stop_q  <= STOP_FAULT;
							fault_q <= rdata_q;
						end
					endcase
				end
				ST_LO: pc_q <= pc_q + 16'd1;
				ST_HI: begin
					if (op_q == OP_JMP_ABS) begin
						pc_q <= abs_addr;
					end else if (op_q == OP_STA_ABS && abs_addr == CONSOLE_ADDR) begin
						char_v_q <= 1'b1;
						char_q   <= acc_q;
					end
				end
				ST_DATA: begin
					acc_q <= rdata_q;
					n_q   <= rdata_q[BYTE_W-1];
					z_q   <= (rdata_q == '0);
				end
				ST_IMM: begin
					y_q <= rdata_q;
					n_q <= rdata_q[BYTE_W-1];
					z_q <= (rdata_q == '0);
				end
				ST_REL: begin
					if (z_q) begin
						pc_q <= pc_q + {{(WORD_W-BYTE_W){rdata_q[BYTE_W-1]}}, rdata_q};
					end
				end
				default: ;
			endcase
			// start address write also reloads the program counter
			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q.program_counter <= pc_q;
			res_q.accumulator     <= acc_q;
			res_q.index_y         <= y_q;
			res_q.negative_flag   <= n_q;
			res_q.zero_flag       <= z_q;
			res_q.stop_reason     <= stop_q;
			res_q.fault_opcode    <= fault_q;
			res_q.char_valid      <= char_v_q;
			res_q.char_out        <= char_q;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.program_counter = res_q.program_counter;
	assign res.accumulator     = res_q.accumulator;
	assign res.index_y         = res_q.index_y;
	assign res.negative_flag   = res_q.negative_flag;
	assign res.zero_flag       = res_q.zero_flag;
	assign res.stop_reason     = res_q.stop_reason;
	assign res.fault_opcode    = res_q.fault_opcode;
	assign res.char_valid      = res_q.char_valid;
	assign res.char_out        = res_q.char_out;

endmodule

### sim/tb_eight_bit_cpu_instruction_subset_unit.sv
// Self-checking testbench for the eight-bit processor subset unit: short test
// programs are loaded and stepped, and every result is checked against a predictor.
// Depends on ebcpu_pkg, ebcpu_in_if, ebcpu_out_if and the unit itself.
`timescale 1ns / 1ps

module tb_eight_bit_cpu_instruction_subset_unit;
	import ebcpu_pkg::*;

	typedef struct packed {
		logic              command;
		logic [WORD_W-1:0] load_address;
		logic [BYTE_W-1:0] load_data;
	} cpu_cmd_t;

	localparam int CLK_HALF     = 10;
	localparam int RANDOM_ITEMS = 1600;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_REPORTS  = 10;
	localparam int LONG_HOLD    = 400;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we;
	logic [WORD_W-1:0] cfg_wdata;

	ebcpu_in_if  cmd_bus ();
	ebcpu_out_if res_bus ();

	eight_bit_cpu_instruction_subset_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_bus),
		.res       (res_bus)
	);

	always #CLK_HALF clk = ~clk;

	// Transactions waiting to be sent, and the register states they should produce
	cpu_cmd_t pending_cmds[$];
	result_t  expected_results[$];

	// Architectural state of the predictor
	logic [BYTE_W-1:0] arch_mem [0:(1 << WORD_W) - 1];
	logic [WORD_W-1:0] arch_pc;
	logic [BYTE_W-1:0] arch_acc;
	logic [BYTE_W-1:0] arch_y;
	logic [BYTE_W-1:0] arch_fault;
	logic              arch_n;
	logic              arch_z;
	logic [STOP_W-1:0] arch_stop;

	int error_count = 0;
	int accepted_cmds;
	int send_gap;
	int calm_tx;
	int hold_left;
	int calm_rx;
	int rx_pause;
	bit long_hold_done;

	// Gap length: mostly none, sometimes short, now and then long
	function automatic int random_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [BYTE_W-1:0] next_byte();
		logic [BYTE_W-1:0] b;
		b = arch_mem[arch_pc];
		arch_pc = arch_pc + 1'b1;
		return b;
	endfunction

	// Operand words are little endian
	function automatic logic [WORD_W-1:0] next_word();
		logic [BYTE_W-1:0] lo;
		logic [BYTE_W-1:0] hi;
		lo = next_byte();
		hi = next_byte();
		return {hi, lo};
	endfunction

	function automatic void set_flags(input logic [BYTE_W-1:0] v);
		arch_z = (v == '0);
		arch_n = v[BYTE_W-1];
	endfunction

	// Predictor: apply one accepted transaction and queue the state it leaves
	task automatic execute_cmd(input cpu_cmd_t c);
		result_t           r;
		logic [BYTE_W-1:0] opc;
		logic [BYTE_W-1:0] rel;
		logic [WORD_W-1:0] ea;
		r = '0;
		if (c.command == CMD_LOAD) begin
			arch_mem[c.load_address] = c.load_data;
		end else if (arch_stop == STOP_RUN) begin
			opc = next_byte();
			case (opc)
				OP_BRK: arch_stop = STOP_BRK;
				OP_JMP_ABS: arch_pc = next_word();
				OP_STA_ABS: begin
					ea = next_word();
					arch_mem[ea] = arch_acc;
					if (ea == CONSOLE_ADDR) begin
						r.char_valid = 1'b1;
						r.char_out   = arch_acc;
					end
				end
				OP_LDY_IMM: begin
					arch_y = next_byte();
					set_flags(arch_y);
				end
				OP_LDA_ABY: begin
					ea = next_word();
					ea = ea + {8'h00, arch_y};
					arch_acc = arch_mem[ea];
					set_flags(arch_acc);
				end
				OP_INY: begin
					arch_y = arch_y + 1'b1;
					set_flags(arch_y);
				end
				OP_BEQ: begin
					rel = next_byte();
					if (arch_z)
						arch_pc = arch_pc + {{8{rel[7]}}, rel};
				end
				default: begin
					arch_stop  = STOP_FAULT;
					arch_fault = opc;
				end
			endcase
		end
		r.program_counter = arch_pc;
		r.accumulator     = arch_acc;
		r.index_y         = arch_y;
		r.negative_flag   = arch_n;
		r.zero_flag       = arch_z;
		r.stop_reason     = arch_stop;
		r.fault_opcode    = arch_fault;
		expected_results.push_back(r);
	endtask

	// Command driver: presents queued transactions with random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_bus.valid        <= 1'b0;
			cmd_bus.command      <= CMD_LOAD;
			cmd_bus.load_address <= '0;
			cmd_bus.load_data    <= '0;
			send_gap             <= 0;
			calm_tx              <= 0;
			accepted_cmds        <= 0;
			for (int i = 0; i < (1 << WORD_W); i++)
				arch_mem[i] = '0;
			arch_pc    = RESET_START;
			arch_acc   = '0;
			arch_y     = '0;
			arch_fault = '0;
			arch_n     = 1'b0;
			arch_z     = 1'b0;
			arch_stop  = STOP_RUN;
		end else begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				execute_cmd({cmd_bus.command, cmd_bus.load_address, cmd_bus.load_data});
				accepted_cmds <= accepted_cmds + 1;
			end
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (send_gap > 0) begin
					cmd_bus.valid <= 1'b0;
					send_gap      <= send_gap - 1;
				end else if (pending_cmds.size() != 0) begin
					cmd_bus.valid        <= 1'b1;
					cmd_bus.command      <= pending_cmds[0].command;
					cmd_bus.load_address <= pending_cmds[0].load_address;
					cmd_bus.load_data    <= pending_cmds[0].load_data;
					void'(pending_cmds.pop_front());
					// occasional runs with no gaps at all
					if (calm_tx > 0) begin
						send_gap <= 0;
						calm_tx  <= calm_tx - 1;
					end else begin
						send_gap <= random_pause();
						if ($urandom_range(0, 99) == 0)
							calm_tx <= $urandom_range(30, 90);
					end
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Compare one result transaction with the oldest expectation
	task automatic check_result();
		result_t got;
		result_t want;
		got.program_counter = res_bus.program_counter;
		got.accumulator     = res_bus.accumulator;
		got.index_y         = res_bus.index_y;
		got.negative_flag   = res_bus.negative_flag;
		got.zero_flag       = res_bus.zero_flag;
		got.stop_reason     = res_bus.stop_reason;
		got.fault_opcode    = res_bus.fault_opcode;
		got.char_valid      = res_bus.char_valid;
		got.char_out        = res_bus.char_out;
		if (expected_results.size() == 0) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: result transaction with nothing outstanding, pc=%h", $time,
					got.program_counter);
			return;
		end
		want = expected_results.pop_front();
		if (got.program_counter !== want.program_counter || got.accumulator !== want.accumulator
				|| got.index_y !== want.index_y || got.negative_flag !== want.negative_flag
				|| got.zero_flag !== want.zero_flag || got.stop_reason !== want.stop_reason
				|| got.fault_opcode !== want.fault_opcode || got.char_valid !== want.char_valid
				|| got.char_out !== want.char_out) begin
			error_count++;
			if (error_count <= MAX_REPORTS) begin
				$display("%0t: mismatch exp pc=%h a=%h y=%h n=%b z=%b stop=%0d fault=%h chr=%b/%h",
					$time, want.program_counter, want.accumulator, want.index_y,
					want.negative_flag, want.zero_flag, want.stop_reason, want.fault_opcode,
					want.char_valid, want.char_out);
				$display("%0t:          got pc=%h a=%h y=%h n=%b z=%b stop=%0d fault=%h chr=%b/%h",
					$time, got.program_counter, got.accumulator, got.index_y,
					got.negative_flag, got.zero_flag, got.stop_reason, got.fault_opcode,
					got.char_valid, got.char_out);
			end
		end
	endtask

	// Result monitor with random back-pressure and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready  <= 1'b0;
			hold_left      <= 0;
			calm_rx        <= 0;
			long_hold_done <= 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready)
				check_result();
			if (hold_left > 0) begin
				res_bus.ready <= 1'b0;
				hold_left     <= hold_left - 1;
			end else if (!long_hold_done && accepted_cmds > 200 && pending_cmds.size() > 24) begin
				// sender still has plenty queued, so the unit backs up
				res_bus.ready  <= 1'b0;
				hold_left      <= LONG_HOLD;
				long_hold_done <= 1'b1;
			end else if (calm_rx > 0) begin
				res_bus.ready <= 1'b1;
				calm_rx       <= calm_rx - 1;
			end else begin
				rx_pause = random_pause();
				res_bus.ready <= (rx_pause == 0);
				hold_left     <= (rx_pause > 0) ? rx_pause - 1 : 0;
				if ($urandom_range(0, 99) == 0)
					calm_rx <= $urandom_range(40, 120);
			end
		end
	end

	task automatic queue_load(input logic [WORD_W-1:0] addr, input logic [BYTE_W-1:0] data);
		cpu_cmd_t c;
		c.command      = CMD_LOAD;
		c.load_address = addr;
		c.load_data    = data;
		pending_cmds.push_back(c);
	endtask

	// Address and data fields of a step are don't-care, so they are randomised too
	task automatic queue_step();
		cpu_cmd_t c;
		c.command      = CMD_STEP;
		c.load_address = WORD_W'($urandom());
		c.load_data    = BYTE_W'($urandom());
		pending_cmds.push_back(c);
	endtask

	// Random address clear of the program area starting at base
	function automatic logic [WORD_W-1:0] outside_addr(input logic [WORD_W-1:0] base,
			input int len);
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] off;
		do begin
			a   = WORD_W'($urandom());
			off = a - base;
		end while (off < len);
		return a;
	endfunction

	// Program area that keeps clear of the console address
	function automatic logic [WORD_W-1:0] pick_base();
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] off;
		do begin
			b   = WORD_W'($urandom());
			off = CONSOLE_ADDR - b;
		end while (off < 64);
		return b;
	endfunction

	// Wait until nothing is queued, in flight or outstanding
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || cmd_bus.valid || expected_results.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_start(input logic [WORD_W-1:0] addr);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= addr;
		@(posedge clk);
		cfg_we    <= 1'b0;
		arch_pc    = addr;
	endtask

	// Build a program at base and step through it, with stray loads mixed in.
	// Every branch and jump lands on an instruction start, so any path stays in
	// valid code; a looping program ends in a jump back to base, a halting one
	// runs straight through to BRK or an undefined opcode.
	task automatic run_program(input logic [WORD_W-1:0] base, input bit halting,
			output int n_items);
		logic [BYTE_W-1:0] ops[$];
		logic [BYTE_W-1:0] code[$];
		int                starts[$];
		int                n_ops;
		int                len;
		int                steps;
		int                t;
		logic [BYTE_W-1:0] op;
		logic [BYTE_W-1:0] b;
		logic [WORD_W-1:0] a;
		n_ops = $urandom_range(3, 12);
		len   = 0;
		for (int i = 0; i < n_ops; i++) begin
			if (i == n_ops - 1 && !halting) begin
				op = OP_JMP_ABS;
			end else if (i == n_ops - 1) begin
				if ($urandom_range(0, 1))
					op = OP_BRK;
				else
					do
						op = BYTE_W'($urandom_range(1, 255));
					while (op inside {OP_JMP_ABS, OP_STA_ABS, OP_LDY_IMM, OP_LDA_ABY, OP_INY,
						OP_BEQ});
			end else begin
				case ($urandom_range(0, halting ? 3 : 8))
					0, 7: op = OP_LDY_IMM;
					1: op = OP_LDA_ABY;
					2, 8: op = OP_INY;
					3: op = OP_STA_ABS;
					4, 5: op = OP_BEQ;
					default: op = OP_JMP_ABS;
				endcase
			end
			ops.push_back(op);
			starts.push_back(len);
			if (op == OP_LDY_IMM || op == OP_BEQ)
				len += 2;
			else if (op inside {OP_JMP_ABS, OP_STA_ABS, OP_LDA_ABY})
				len += 3;
			else
				len += 1;
		end

		// operands
		for (int i = 0; i < n_ops; i++) begin
			code.push_back(ops[i]);
			case (ops[i])
				OP_LDY_IMM: begin
					case ($urandom_range(0, 5))
						0: b = 8'h00;
						1: b = 8'hFF;
						2: b = 8'h7F;
						3: b = 8'h80;
						default: b = BYTE_W'($urandom());
					endcase
					code.push_back(b);
				end
				OP_BEQ: begin
					t = $urandom_range(0, n_ops - 1);
					code.push_back(BYTE_W'(starts[t] - starts[i] - 2));
				end
				OP_JMP_ABS: begin
					t = (i == n_ops - 1) ? 0 : $urandom_range(0, n_ops - 1);
					a = base + WORD_W'(starts[t]);
					code.push_back(a[7:0]);
					code.push_back(a[15:8]);
				end
				OP_STA_ABS: begin
					a = ($urandom_range(0, 2) == 0) ? CONSOLE_ADDR : outside_addr(base, len);
					code.push_back(a[7:0]);
					code.push_back(a[15:8]);
				end
				OP_LDA_ABY: begin
					// top page now and then, so the index carries past 0xFFFF
					a = ($urandom_range(0, 3) == 0) ? WORD_W'($urandom_range(16'hFF00, 16'hFFFF))
						: WORD_W'($urandom());
					code.push_back(a[7:0]);
					code.push_back(a[15:8]);
				end
				default: ;
			endcase
		end

		n_items = 0;
		for (int i = 0; i < code.size(); i++) begin
			if ($urandom_range(0, 4) == 0) begin
				queue_load(outside_addr(base, len), BYTE_W'($urandom()));
				n_items++;
			end
			queue_load(base + WORD_W'(i), code[i]);
			n_items++;
		end
		steps = halting ? n_ops + $urandom_range(3, 10) : $urandom_range(8, 60);
		for (int i = 0; i < steps; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				queue_load(outside_addr(base, len), BYTE_W'($urandom()));
				n_items++;
			end
			queue_step();
			n_items++;
		end
	endtask

	// Stimulus sequence and end of run
	initial begin
		int                sent;
		int                n;
		int                phase;
		logic [WORD_W-1:0] base;
		cfg_we               <= 1'b0;
		cfg_wdata            <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed program at the reset start address: taken branches at both
		// offset extremes, Y wrap on INY, indexed address wrap, console store
		queue_load(16'h0600, OP_LDY_IMM);
		queue_load(16'h0601, 8'h00);
		queue_load(16'h0602, OP_BEQ);
		queue_load(16'h0603, 8'h7F);
		queue_load(16'h0683, OP_LDY_IMM);
		queue_load(16'h0684, 8'hFF);
		queue_load(16'h0685, OP_LDA_ABY);
		queue_load(16'h0686, 8'hFF);
		queue_load(16'h0687, 8'hFF);
		queue_load(16'h0688, OP_STA_ABS);
		queue_load(16'h0689, CONSOLE_ADDR[7:0]);
		queue_load(16'h068A, CONSOLE_ADDR[15:8]);
		queue_load(16'h068B, OP_INY);
		queue_load(16'h068C, OP_BEQ);
		queue_load(16'h068D, 8'h80);
		queue_load(16'h060E, OP_JMP_ABS);
		queue_load(16'h060F, 8'h34);
		queue_load(16'h0610, 8'h12);
		queue_load(16'h00FE, 8'h80);
		repeat (8) queue_step();
		wait_idle();

		// Random programs, each from a fresh start address
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case (phase)
				0: base = 16'h0000;
				1: base = 16'hFFFF;
				2: base = RESET_START;
				default: base = pick_base();
			endcase
			set_start(base);
			run_program(base, 1'b0, n);
			sent += n;
			wait_idle();
			phase++;
		end

		// Halting program last: nothing runs after it
		base = pick_base();
		set_start(base);
		run_program(base, 1'b1, n);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Run limit: memory clearing pass plus the slowest stimulus, with margin
	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
